// ===== hdl/sfcd_pkg.sv =====
// Shared types and constants for the SBUS frame channel decoder.
package sfcd_pkg;

	localparam int CHANNELS   = 16;
	localparam int DATA_BYTES = 22;
	localparam int RAW_W      = 11;
	localparam int BYTE_W     = 8;
	localparam int POS_W      = 5;
	localparam int IDX_W      = 4;
	localparam int VAL_W      = 16;
	localparam int OUT_W      = 15;
	localparam int DIFF_W     = RAW_W + 1;
	localparam int PROD_W     = DIFF_W + VAL_W;
	localparam int MAG_W      = PROD_W - 1;
	localparam int CNT_W      = 5;
	localparam int ADDR_W     = 5;

	localparam logic [POS_W-1:0] POS_MAX  = 5'd31;
	localparam logic [POS_W-1:0] LAST_COL = 5'(DATA_BYTES - 1);
	localparam logic [IDX_W-1:0] LAST_CH  = 4'(CHANNELS - 1);

	localparam logic [7:0]  HDR_RST  = 8'd15;
	localparam logic [3:0]  SHIFT_RST = 4'd2;
	localparam logic [10:0] RMIN_RST = 11'd172;
	localparam logic [10:0] RMAX_RST = 11'd1811;
	localparam logic [14:0] OMIN_RST = 15'd1000;
	localparam logic [14:0] OMAX_RST = 15'd2000;

	typedef enum logic [2:0] {
		REG_HEADER  = 3'd0,
		REG_SHIFT   = 3'd1,
		REG_RAW_MIN = 3'd2,
		REG_RAW_MAX = 3'd3,
		REG_OUT_MIN = 3'd4,
		REG_OUT_MAX = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		SS_SEARCH,
		SS_COLLECT,
		SS_IDLE
	} search_t;

	typedef enum logic [2:0] {
		PH_IN,
		PH_MUL,
		PH_DSTART,
		PH_DIV,
		PH_OUT,
		PH_ERR
	} phase_t;

	typedef struct packed {
		logic [7:0]       header_byte;
		logic [3:0]       max_shift;
		logic [RAW_W-1:0] raw_min;
		logic [RAW_W-1:0] raw_max;
		logic [OUT_W-1:0] out_min;
		logic [OUT_W-1:0] out_max;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== hdl/sbus_frame_channel_decoder.sv =====
// SBUS frame channel decoder: header search, 22-byte collection, 16-channel scaling.
// Input bytes are taken one per cycle while searching or collecting (s_tready high).
// After the last data byte, each channel goes through multiply, the 27-step shared
// divider and output load, or multiply and output load alone when raw_max equals
// raw_min, plus any output stall; input is held off meanwhile. A missing header gives
// one error transaction via the error state once the output is free. arst_n clears control, loads defaults.
module sbus_frame_channel_decoder
	import sfcd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] byte_in
	input  logic [0:0]        s_tuser,   // [0] buffer_start
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,   // [3:0] channel_index, [19:4] channel_value
	output logic [0:0]        m_tuser,   // [0] status
	output logic              m_tlast
);

	localparam int FRAME_W = DATA_BYTES * BYTE_W;

	cfg_t       cfg;
	div_stat_t  dstat;
	phase_t     phase_q, phase_d;
	search_t    ss_q, ss_eff;
	logic [POS_W-1:0]   pos_q, pos_eff, coll_q, coll_eff;
	logic [FRAME_W-1:0] frame_q;
	logic [IDX_W-1:0]   idx_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DIFF_W-1:0] raw_diff, den;
	logic signed [VAL_W-1:0]  out_diff, omin_x;
	logic [VAL_W-1:0]   val_q, quo;
	logic               in_acc, out_free, hdr_hit, win_end, col_done;
	logic               mv_q, ml_q, ms_q;
	logic [IDX_W-1:0]   mi_q;
	logic [VAL_W-1:0]   mval_q;

	sfcd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfcd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (phase_q == PH_DSTART),
		.dividend (prod_q),
		.divisor  (den),
		.quotient (quo),
		.stat     (dstat)
	);

	assign s_tready = (phase_q == PH_IN);
	assign in_acc   = s_tvalid & s_tready;
	assign out_free = !mv_q || m_tready;

	assign ss_eff   = s_tuser[0] ? SS_SEARCH : ss_q;
	assign pos_eff  = s_tuser[0] ? '0 : pos_q;
	assign coll_eff = s_tuser[0] ? '0 : coll_q;
	assign hdr_hit  = (s_tdata == cfg.header_byte) && (pos_eff <= {1'b0, cfg.max_shift});
	assign win_end  = pos_eff >= {1'b0, cfg.max_shift};
	assign col_done = coll_eff == LAST_COL;

	assign raw_diff = $signed({1'b0, frame_q[RAW_W-1:0]}) - $signed({1'b0, cfg.raw_min});
	assign den      = $signed({1'b0, cfg.raw_max}) - $signed({1'b0, cfg.raw_min});
	assign omin_x   = VAL_W'($signed(cfg.out_min));
	assign out_diff = VAL_W'($signed(cfg.out_max)) - omin_x;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IN: begin
				if (in_acc && ss_eff == SS_SEARCH && !hdr_hit && win_end)
					phase_d = PH_ERR;
				else if (in_acc && ss_eff == SS_COLLECT && col_done)
					phase_d = PH_MUL;
			end
			PH_MUL:    phase_d = (den == '0) ? PH_OUT : PH_DSTART;
			PH_DSTART: phase_d = PH_DIV;
			PH_DIV:    phase_d = dstat.done ? PH_OUT : PH_DIV;
			PH_OUT: begin
				if (out_free)
					phase_d = (idx_q == LAST_CH) ? PH_IN : PH_MUL;
			end
			PH_ERR:    phase_d = out_free ? PH_IN : PH_ERR;
			default:   phase_d = PH_IN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IN;
			ss_q    <= SS_SEARCH;
			pos_q   <= '0;
			coll_q  <= '0;
			idx_q   <= '0;
			mv_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (in_acc) begin
				pos_q  <= (pos_eff == POS_MAX) ? POS_MAX : pos_eff + 1'b1;
				ss_q   <= ss_eff;
				coll_q <= coll_eff;
				unique case (ss_eff)
					SS_SEARCH: begin
						if (hdr_hit) begin
							ss_q   <= SS_COLLECT;
							coll_q <= '0;
						end else if (win_end) begin
							ss_q <= SS_IDLE;
						end
					end
					SS_COLLECT: begin
						if (col_done) begin
							ss_q   <= SS_IDLE;
							coll_q <= '0;
							idx_q  <= '0;
						end else begin
							coll_q <= coll_eff + 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (mv_q && m_tready)
				mv_q <= 1'b0;
			if ((phase_q == PH_OUT || phase_q == PH_ERR) && out_free)
				mv_q <= 1'b1;
			if (phase_q == PH_OUT && out_free)
				idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && ss_eff == SS_COLLECT)
			frame_q <= {s_tdata, frame_q[FRAME_W-1:BYTE_W]};
		else if (phase_q == PH_OUT && out_free)
			frame_q <= {{RAW_W{1'b0}}, frame_q[FRAME_W-1:RAW_W]};
		if (phase_q == PH_MUL) begin
			prod_q <= PROD_W'(raw_diff * out_diff);
			val_q  <= omin_x;
		end
		if (phase_q == PH_DIV && dstat.done)
			val_q <= quo + omin_x;
		if (phase_q == PH_OUT && out_free) begin
			mi_q   <= idx_q;
			mval_q <= val_q;
			ms_q   <= 1'b0;
			ml_q   <= (idx_q == LAST_CH);
		end else if (phase_q == PH_ERR && out_free) begin
			mi_q   <= '0;
			mval_q <= '0;
			ms_q   <= 1'b1;
			ml_q   <= 1'b1;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = {4'd0, mval_q, mi_q};
	assign m_tuser  = ms_q;
	assign m_tlast  = ml_q;

endmodule

// ===== hdl/sfcd_regs.sv =====
// APB configuration registers for the SBUS frame channel decoder.
module sfcd_regs
	import sfcd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t widx;
	logic     wr_en;

	assign pready = 1'b1;
	assign cfg    = cfg_q;
	assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte <= HDR_RST;
			cfg_q.max_shift   <= SHIFT_RST;
			cfg_q.raw_min     <= RMIN_RST;
			cfg_q.raw_max     <= RMAX_RST;
			cfg_q.out_min     <= OMIN_RST;
			cfg_q.out_max     <= OMAX_RST;
		end else if (wr_en) begin
			case (widx)
				REG_HEADER:  cfg_q.header_byte <= pwdata[7:0];
				REG_SHIFT:   cfg_q.max_shift   <= pwdata[3:0];
				REG_RAW_MIN: cfg_q.raw_min     <= pwdata[RAW_W-1:0];
				REG_RAW_MAX: cfg_q.raw_max     <= pwdata[RAW_W-1:0];
				REG_OUT_MIN: cfg_q.out_min     <= pwdata[OUT_W-1:0];
				REG_OUT_MAX: cfg_q.out_max     <= pwdata[OUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (widx)
			REG_HEADER:  prdata = {24'd0, cfg_q.header_byte};
			REG_SHIFT:   prdata = {28'd0, cfg_q.max_shift};
			REG_RAW_MIN: prdata = {21'd0, cfg_q.raw_min};
			REG_RAW_MAX: prdata = {21'd0, cfg_q.raw_max};
			REG_OUT_MIN: prdata = {17'd0, cfg_q.out_min};
			REG_OUT_MAX: prdata = {17'd0, cfg_q.out_max};
			default:     prdata = '0;
		endcase
	end

endmodule

// ===== hdl/sfcd_div.sv =====
// Shared radix-2 restoring signed divider, quotient truncated toward zero.
module sfcd_div
	import sfcd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [PROD_W-1:0] dividend,
	input  logic signed [DIFF_W-1:0] divisor,
	output logic        [VAL_W-1:0]  quotient,
	output div_stat_t                stat
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [RAW_W-1:0] dmag_q;
	logic [RAW_W-1:0] rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [PROD_W-1:0] nabs;
	logic [DIFF_W-1:0] dabs;
	logic [DIFF_W-1:0] trial;

	assign nabs  = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
	assign dabs  = divisor[DIFF_W-1] ? DIFF_W'(-divisor) : DIFF_W'(divisor);
	assign trial = {rem_q, quo_q[MAG_W-1]} - {1'b0, dmag_q};

	assign quotient  = neg_q ? VAL_W'(-quo_q) : quo_q[VAL_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MAG_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= dividend[PROD_W-1] ^ divisor[DIFF_W-1];
			dmag_q <= dabs[RAW_W-1:0];
			rem_q  <= '0;
			quo_q  <= nabs[MAG_W-1:0];
		end else if (busy_q) begin
			if (!trial[DIFF_W-1]) begin
				rem_q <= trial[RAW_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[RAW_W-2:0], quo_q[MAG_W-1]};
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== tb/frame_decode_checker.sv =====
// Channel monitor: mirrors register writes, predicts decoded channels, compares results.
`timescale 1ns / 100ps

module frame_decode_checker
	import sfcd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic [0:0]        s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [23:0]       m_tdata,
	input  logic [0:0]        m_tuser,
	input  logic              m_tlast,
	output int                fail_total,
	output int                pending,
	output int                frames_done,
	output int                hdr_misses
);

	typedef struct packed {
		logic [IDX_W-1:0] ch;
		logic [VAL_W-1:0] level;
		logic             err;
		logic             tail;
	} chan_word_t;

	cfg_t             cfg;
	logic [POS_W-1:0] scan_pos;
	search_t          hunt;
	int               ncollected;
	logic [7:0]       frame_buf [DATA_BYTES];
	chan_word_t       expected_q [$];
	int               nfail;
	int               nframes;
	int               nmiss;

	function automatic logic [VAL_W-1:0] scale_raw(input logic [RAW_W-1:0] raw);
		longint span_in;
		longint lo;
		longint acc;
		span_in = longint'(cfg.raw_max) - longint'(cfg.raw_min);
		lo      = longint'($signed(cfg.out_min));
		if (span_in == 0)
			acc = lo;
		else
			acc = (longint'(raw) - longint'(cfg.raw_min)) *
			      (longint'($signed(cfg.out_max)) - lo) / span_in + lo;
		return acc[VAL_W-1:0];
	endfunction

	task automatic take_byte(input logic [7:0] b, input logic first);
		logic [POS_W-1:0]        here;
		logic [8*DATA_BYTES-1:0] bits;
		chan_word_t              w;
		int                      i;
		if (first) begin
			scan_pos   = '0;
			hunt       = SS_SEARCH;
			ncollected = 0;
		end
		here = scan_pos;
		if (scan_pos != POS_MAX)
			scan_pos++;
		case (hunt)
			SS_SEARCH: begin
				if (b == cfg.header_byte && here <= cfg.max_shift) begin
					hunt       = SS_COLLECT;
					ncollected = 0;
				end else if (here >= cfg.max_shift) begin
					hunt = SS_IDLE;
					w    = '{ch: '0, level: '0, err: 1'b1, tail: 1'b1};
					expected_q.push_back(w);
					nmiss++;
				end
			end
			SS_COLLECT: begin
				frame_buf[ncollected] = b;
				ncollected++;
				if (ncollected == DATA_BYTES) begin
					hunt       = SS_IDLE;
					ncollected = 0;
					for (i = 0; i < DATA_BYTES; i++)
						bits[8*i +: 8] = frame_buf[i];
					for (i = 0; i < CHANNELS; i++) begin
						w.ch    = IDX_W'(i);
						w.level = scale_raw(bits[RAW_W*i +: RAW_W]);
						w.err   = 1'b0;
						w.tail  = (i == CHANNELS - 1);
						expected_q.push_back(w);
					end
					nframes++;
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_result();
		chan_word_t got;
		chan_word_t want;
		got = '{ch: m_tdata[3:0], level: m_tdata[19:4], err: m_tuser[0], tail: m_tlast};
		if (expected_q.size() == 0) begin
			nfail++;
			if (nfail <= 10)
				$display("%0t: result with nothing expected: ch %0d value %0d status %0b last %0b",
					$time, got.ch, $signed(got.level), got.err, got.tail);
		end else begin
			want = expected_q.pop_front();
			if (got != want) begin
				nfail++;
				if (nfail <= 10)
					$display("%0t: mismatch exp ch %0d val %0d st %0b last %0b / got ch %0d val %0d st %0b last %0b",
						$time, want.ch, $signed(want.level), want.err, want.tail,
						got.ch, $signed(got.level), got.err, got.tail);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg        = '{HDR_RST, SHIFT_RST, RMIN_RST, RMAX_RST, OMIN_RST, OMAX_RST};
			scan_pos   = '0;
			hunt       = SS_SEARCH;
			ncollected = 0;
			nfail      = 0;
			nframes    = 0;
			nmiss      = 0;
			expected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_HEADER:  cfg.header_byte = pwdata[7:0];
					REG_SHIFT:   cfg.max_shift   = pwdata[3:0];
					REG_RAW_MIN: cfg.raw_min     = pwdata[RAW_W-1:0];
					REG_RAW_MAX: cfg.raw_max     = pwdata[RAW_W-1:0];
					REG_OUT_MIN: cfg.out_min     = pwdata[OUT_W-1:0];
					REG_OUT_MAX: cfg.out_max     = pwdata[OUT_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_byte(s_tdata, s_tuser[0]);
			if (m_tvalid && m_tready)
				check_result();
		end
		fail_total  <= nfail;
		pending     <= expected_q.size();
		frames_done <= nframes;
		hdr_misses  <= nmiss;
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top: clock, reset, register setup, byte stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb;
	import sfcd_pkg::*;

	localparam int RAND_ITEMS = 430;
	localparam int PHASES     = 6;
	localparam int LIMIT      = 500000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;   // [7:0] byte_in
	logic [0:0]        s_tuser;   // [0] buffer_start
	logic              m_tvalid;
	logic              m_tready = 1'b1;
	logic [23:0]       m_tdata;   // [3:0] channel_index, [19:4] channel_value
	logic [0:0]        m_tuser;   // [0] status
	logic              m_tlast;

	int         fail_total;
	int         pending;
	int         frames_done;
	int         hdr_misses;
	int         cycles = 0;
	int         hold_left = 0;
	int         bytes_sent = 0;
	bit         idle_on = 1'b1;
	logic [7:0] hdr_sel;
	logic [3:0] shift_sel;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sbus_frame_channel_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	frame_decode_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.fail_total  (fail_total),
		.pending     (pending),
		.frames_done (frames_done),
		.hdr_misses  (hdr_misses)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			hold_left <= $urandom_range(0, 2);
			m_tready  <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [7:0] hdr, input logic [3:0] shift,
			input int rmin, input int rmax, input int omin, input int omax);
		reg_write(REG_HEADER, {24'h0, hdr});
		reg_write(REG_SHIFT, {28'h0, shift});
		reg_write(REG_RAW_MIN, 32'(rmin) & 32'h7FF);
		reg_write(REG_RAW_MAX, 32'(rmax) & 32'h7FF);
		reg_write(REG_OUT_MIN, 32'(omin) & 32'h7FFF);
		reg_write(REG_OUT_MAX, 32'(omax) & 32'h7FFF);
		hdr_sel   = hdr;
		shift_sel = shift;
	endtask

	task automatic push_byte(input logic [7:0] b, input logic first);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// wait until every predicted result is out, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [7:0] other_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == hdr_sel);
		return b;
	endfunction

	task automatic send_frame(input int lead, input int data_len, input int mode);
		int         i;
		logic [7:0] b;
		for (i = 0; i < lead; i++)
			push_byte(other_byte(), i == 0);
		push_byte(hdr_sel, lead == 0);
		for (i = 0; i < data_len; i++) begin
			case (mode)
				0: b = 8'h00;
				1: b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			push_byte(b, 1'b0);
		end
	endtask

	task automatic random_sequence();
		int kind;
		int lead;
		int i;
		kind = $urandom_range(0, 9);
		lead = $urandom_range(0, shift_sel);
		if (kind <= 6) begin
			send_frame(lead, DATA_BYTES, $urandom_range(0, 7));
			repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0);
		end else if (kind == 7) begin
			for (i = 0; i <= shift_sel; i++)
				push_byte(other_byte(), i == 0);
			if ($urandom_range(0, 1) != 0)
				push_byte(hdr_sel, 1'b0);
		end else if (kind == 8)
			send_frame(lead, $urandom_range(1, DATA_BYTES - 1), 2);
		else
			repeat ($urandom_range(1, 8))
				push_byte(($urandom_range(0, 3) == 0) ? hdr_sel : 8'($urandom),
					$urandom_range(0, 7) == 0);
	endtask

	initial begin
		int phase;
		int rmin;
		int base;
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		hdr_sel   = HDR_RST;
		shift_sel = SHIFT_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first frame without any start flag, all-ones data
		push_byte(HDR_RST, 1'b0);
		repeat (DATA_BYTES) push_byte(8'hFF, 1'b0);
		// ignored after a finished frame
		push_byte(8'hA5, 1'b0);
		push_byte(HDR_RST, 1'b0);
		// header missing in the window
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h10, 1'b0);
		push_byte(HDR_RST, 1'b0);
		// header at the last allowed position, then restart while collecting
		push_byte(8'h0E, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(HDR_RST, 1'b0);
		repeat (5) push_byte(8'($urandom), 1'b0);
		push_byte(HDR_RST, 1'b1);
		repeat (DATA_BYTES) push_byte(8'h00, 1'b0);
		drain();

		base = bytes_sent;
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: apply_settings(8'h00, 4'd0, 0, 2047, -16384, 16383);
				1: apply_settings(8'hFF, 4'd15, 2047, 0, 16383, -16384);
				2: apply_settings(8'hA5, 4'd3, 1000, 1000, -1234, 500);
				default: begin
					rmin = $urandom_range(0, 2047);
					apply_settings(8'($urandom), 4'($urandom_range(0, 7)), rmin,
						($urandom_range(0, 5) == 0) ? rmin : $urandom_range(0, 2047),
						$urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384);
				end
			endcase
			idle_on = (phase != PHASES - 1);
			while (bytes_sent < base + ((phase + 1) * (RAND_ITEMS - base)) / PHASES)
				random_sequence();
			drain();
		end

		$display("Run covered %0d input bytes under %0d register settings, %0d cycles",
			bytes_sent, PHASES + 1, cycles);
		$display("Decoded %0d frames into channels and saw %0d missing-header reports",
			frames_done, hdr_misses);
		if (fail_total == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
